// ===== rtl/framed_reply_packet_receiver_unit_defines.svh =====
// Assertion macros for the framed reply packet receiver.
`ifndef FRAMED_REPLY_PACKET_RECEIVER_UNIT_DEFINES_SVH
`define FRAMED_REPLY_PACKET_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define FRPRU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frpru assertion failed");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define FRPRU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frpru assertion failed");

`endif

// ===== rtl/frpru_pkg.sv =====
package frpru_pkg;

    localparam logic [7:0] START_CODE  = 8'h7E;
    localparam logic [7:0] END_CODE    = 8'hE7;
    localparam logic [9:0] MAX_PAYLOAD = 10'd600;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TOO_LONG = 3'd1;
    localparam logic [2:0] ST_SHORT    = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;

    localparam logic REG_LABEL  = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    typedef struct packed {
        logic       is_status;
        logic [7:0] payload_byte;
        logic [2:0] status_code;
    } t_result;

endpackage

// ===== rtl/frpru_out_queue.sv =====
module frpru_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  frpru_pkg::t_result i_push_data,
    input  logic               i_pop_stall,
    output logic               o_valid,
    output logic               o_full,
    output frpru_pkg::t_result o_data
);
    import frpru_pkg::*;

    t_result    r_q [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       pop;
    logic [1:0] widx;

    assign pop     = (r_cnt != 2'd0) && !i_pop_stall;
    assign widx    = r_cnt - {1'b0, pop};
    assign n_cnt   = r_cnt + {1'b0, i_push} - {1'b0, pop};
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_q[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !widx[0]) begin
            r_q[0] <= i_push_data;
        end else if (pop) begin
            r_q[0] <= r_q[1];
        end
        if (i_push && widx[0]) begin
            r_q[1] <= i_push_data;
        end
    end

endmodule

// ===== rtl/framed_reply_packet_receiver_unit.sv =====
// Framed reply packet receiver.
// Input channel (i_in_valid / o_in_stall): one beat per serial event, i_kind 0
// for a received byte in i_rx_byte, 1 for a line-idle timeout.
// Output channel (o_out_valid / i_out_stall): payload byte beats (o_is_status
// low) as they arrive, then one status beat closing each packet attempt:
// 0 ok, 1 too long, 2 short read, 3 bad start or end byte, 4 label or length
// mismatch. Drop the payload when the status is not ok.
// Configuration: APB registers expected_label at 0x0, expected_length at 0x4;
// write them only while the block is idle.
// Throughput: one beat per cycle while the output queue is not full. Each
// result passes through the input register, then a 2-entry output queue that
// holds results while the consumer stalls.
// When the output queue fills, o_in_stall rises and the input register holds
// its beat; no beat is lost.
// Reset: the parser returns to waiting for a start byte, the input register and
// the output queue empty, both configuration registers read as zero.
module framed_reply_packet_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_status,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_status_code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import frpru_pkg::*;

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_LABEL   = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_PURGE   = 3'd5
    } t_phase;

    logic [7:0] r_exp_label;
    logic [9:0] r_exp_len;

    logic       r_in_vld;
    logic       r_in_kind;
    logic [7:0] r_in_byte;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [9:0] r_cnt;
    logic [9:0] n_cnt;
    logic [7:0] r_len_lo;
    logic [7:0] n_len_lo;

    logic       res_vld;
    t_result    res;
    logic       q_full;
    t_result    q_data;
    logic       proc;
    logic       in_acc;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_LENGTH) ? {22'd0, r_exp_len} : {24'd0, r_exp_label};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_label <= 8'd0;
            r_exp_len   <= 10'd0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_LABEL:  r_exp_label <= pwdata[7:0];
                REG_LENGTH: r_exp_len   <= pwdata[9:0];
                default:    r_exp_label <= r_exp_label;
            endcase
        end
    end

    assign proc       = r_in_vld && !q_full;
    assign o_in_stall = r_in_vld && q_full;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_rx_byte;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_len_lo = r_len_lo;
        res_vld  = 1'b0;
        res      = '0;
        case (r_phase)
            PH_LABEL, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD: begin
                if (r_in_kind) begin
                    n_phase         = PH_WAIT;
                    n_cnt           = 10'd0;
                    res_vld         = 1'b1;
                    res.is_status   = 1'b1;
                    res.status_code = ST_SHORT;
                end else if (r_phase == PH_LABEL) begin
                    if (r_cnt == 10'd0 && r_in_byte != r_exp_label) begin
                        n_cnt = {7'd0, ST_MISMATCH};
                    end
                    n_phase = PH_LEN_LO;
                end else if (r_phase == PH_LEN_LO) begin
                    n_len_lo = r_in_byte;
                    n_phase  = PH_LEN_HI;
                end else if (r_phase == PH_LEN_HI) begin
                    n_cnt = 10'd0;
                    if (r_cnt != 10'd0) begin
                        n_phase         = PH_PURGE;
                        res_vld         = 1'b1;
                        res.is_status   = 1'b1;
                        res.status_code = r_cnt[2:0];
                    end else if ({r_in_byte, r_len_lo} != {6'd0, r_exp_len}) begin
                        n_phase         = PH_PURGE;
                        res_vld         = 1'b1;
                        res.is_status   = 1'b1;
                        res.status_code = ST_MISMATCH;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end else if (r_cnt < r_exp_len) begin
                    n_cnt            = r_cnt + 10'd1;
                    res_vld          = 1'b1;
                    res.payload_byte = r_in_byte;
                end else begin
                    n_cnt           = 10'd0;
                    res_vld         = 1'b1;
                    res.is_status   = 1'b1;
                    if (r_in_byte == END_CODE) begin
                        n_phase         = PH_WAIT;
                        res.status_code = ST_OK;
                    end else begin
                        n_phase         = PH_PURGE;
                        res.status_code = ST_INVALID;
                    end
                end
            end
            PH_PURGE: begin
                if (r_in_kind) begin
                    n_phase = PH_WAIT;
                    n_cnt   = 10'd0;
                end
            end
            default: begin
                n_phase = PH_WAIT;
                n_cnt   = 10'd0;
                if (r_exp_len > MAX_PAYLOAD) begin
                    res_vld         = 1'b1;
                    res.is_status   = 1'b1;
                    res.status_code = ST_TOO_LONG;
                end else if (r_in_kind) begin
                    res_vld         = 1'b1;
                    res.is_status   = 1'b1;
                    res.status_code = ST_SHORT;
                end else begin
                    n_cnt   = (r_in_byte != START_CODE) ? {7'd0, ST_INVALID} : 10'd0;
                    n_phase = PH_LABEL;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT;
            r_cnt    <= 10'd0;
            r_len_lo <= 8'd0;
        end else if (proc) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_len_lo <= n_len_lo;
        end
    end

    frpru_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (proc && res_vld),
        .i_push_data (res),
        .i_pop_stall (i_out_stall),
        .o_valid     (o_out_valid),
        .o_full      (q_full),
        .o_data      (q_data)
    );

    assign o_is_status    = q_data.is_status;
    assign o_payload_byte = q_data.payload_byte;
    assign o_status_code  = q_data.status_code;

endmodule

// ===== rtl/frpru_checker.sv =====
`include "framed_reply_packet_receiver_unit_defines.svh"

module frpru_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_is_status,
    input logic [7:0]  o_payload_byte,
    input logic [2:0]  o_status_code
);
    import frpru_pkg::*;

    `FRPRU_ASSERT_IMPL(a_status_range, o_out_valid && o_is_status, o_status_code <= ST_MISMATCH)
    `FRPRU_ASSERT_IMPL(a_byte_code_zero, o_out_valid && !o_is_status, o_status_code == ST_OK)
    `FRPRU_ASSERT_IMPL(a_status_byte_zero, o_out_valid && o_is_status, o_payload_byte == 8'd0)
    `FRPRU_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_is_status) && $stable(o_payload_byte) && $stable(o_status_code))

endmodule

bind framed_reply_packet_receiver_unit frpru_checker u_frpru_checker (.*);

// ===== dv/tb_framed_reply_packet_receiver_unit.sv =====
`timescale 1ns / 100ps

module tb_framed_reply_packet_receiver_unit;
    import frpru_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned IDLE_PERCENT  = 7;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_LABEL,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_PURGE
    } t_parse_phase;

    typedef logic [7:0] t_byte_q[$];

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic        i_kind         = 1'b0;
    logic [7:0]  i_rx_byte      = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic        o_is_status;
    logic [7:0]  o_payload_byte;
    logic [2:0]  o_status_code;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = 3'd0;
    logic [31:0] pwdata         = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // deframer state mirrored in the testbench
    t_parse_phase rx_phase  = PH_WAIT;
    logic [9:0]   rx_count  = 10'd0;
    logic [7:0]   rx_len_lo = 8'h00;
    logic [7:0]   cfg_label  = 8'h00;
    logic [9:0]   cfg_length = 10'd0;

    t_result     expected_results[$];
    t_result     oldest_result;
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned beats_sent  = 0;
    int unsigned hold_left   = 0;
    logic        idle_en     = 1'b1;

    framed_reply_packet_receiver_unit i_dut (.*);

    always #2 i_clk = ~i_clk;

    task automatic parse_beat(input logic kind, input logic [7:0] b);
        t_result     r;
        logic        emit;
        logic [15:0] hdr_len;
        r    = '0;
        emit = 1'b0;
        if (kind == KIND_TIMEOUT &&
            rx_phase inside {PH_LABEL, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD}) begin
            rx_phase      = PH_WAIT;
            rx_count      = 10'd0;
            emit          = 1'b1;
            r.is_status   = 1'b1;
            r.status_code = ST_SHORT;
        end else begin
            case (rx_phase)
                PH_LABEL: begin
                    if (rx_count == 10'd0 && b != cfg_label)
                        rx_count = {7'd0, ST_MISMATCH};
                    rx_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    rx_len_lo = b;
                    rx_phase  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    hdr_len = {b, rx_len_lo};
                    if (rx_count == 10'd0 && hdr_len != {6'd0, cfg_length})
                        rx_count = {7'd0, ST_MISMATCH};
                    if (rx_count != 10'd0) begin
                        emit          = 1'b1;
                        r.is_status   = 1'b1;
                        r.status_code = rx_count[2:0];
                        rx_phase      = PH_PURGE;
                    end else begin
                        rx_phase = PH_PAYLOAD;
                    end
                    rx_count = 10'd0;
                end
                PH_PAYLOAD: begin
                    emit = 1'b1;
                    if (rx_count < cfg_length) begin
                        rx_count       = rx_count + 10'd1;
                        r.payload_byte = b;
                    end else begin
                        rx_count    = 10'd0;
                        r.is_status = 1'b1;
                        if (b == END_CODE) begin
                            rx_phase      = PH_WAIT;
                            r.status_code = ST_OK;
                        end else begin
                            rx_phase      = PH_PURGE;
                            r.status_code = ST_INVALID;
                        end
                    end
                end
                PH_PURGE: begin
                    if (kind == KIND_TIMEOUT) begin
                        rx_phase = PH_WAIT;
                        rx_count = 10'd0;
                    end
                end
                default: begin
                    rx_phase = PH_WAIT;
                    rx_count = 10'd0;
                    if (cfg_length > MAX_PAYLOAD) begin
                        emit          = 1'b1;
                        r.is_status   = 1'b1;
                        r.status_code = ST_TOO_LONG;
                    end else if (kind == KIND_TIMEOUT) begin
                        emit          = 1'b1;
                        r.is_status   = 1'b1;
                        r.status_code = ST_SHORT;
                    end else begin
                        rx_count = (b != START_CODE) ? {7'd0, ST_INVALID} : 10'd0;
                        rx_phase = PH_LABEL;
                    end
                end
            endcase
        end
        if (emit)
            expected_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                parse_beat(i_kind, i_rx_byte);
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected: is_status %0d byte %0h code %0d",
                           o_is_status, o_payload_byte, o_status_code);
                    fail_count++;
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (o_is_status !== oldest_result.is_status) begin
                        $error("is_status: expected %0d, actual %0d",
                               oldest_result.is_status, o_is_status);
                        fail_count++;
                    end
                    if (o_payload_byte !== oldest_result.payload_byte) begin
                        $error("payload_byte: expected %0h, actual %0h",
                               oldest_result.payload_byte, o_payload_byte);
                        fail_count++;
                    end
                    if (o_status_code !== oldest_result.status_code) begin
                        $error("status_code: expected %0d, actual %0d",
                               oldest_result.status_code, o_status_code);
                        fail_count++;
                    end
                end
            end
        end
    end

    // consumer stall: long hold-off on request, else random idling
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= idle_en && ($urandom_range(99, 0) < IDLE_PERCENT);
        end
    end

    task automatic send_beat(input logic kind, input logic [7:0] b);
        while (idle_en && $urandom_range(99, 0) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        beats_sent++;
    endtask

    task automatic send_bytes(input t_byte_q seq);
        foreach (seq[i])
            send_beat(KIND_BYTE, seq[i]);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] stored;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (reg_idx == REG_LABEL) begin
            cfg_label = value[7:0];
            stored    = {24'd0, value[7:0]};
        end else begin
            cfg_length = value[9:0];
            stored     = {22'd0, value[9:0]};
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        if (readback !== stored) begin
            $error("register %0d readback: expected %0h, actual %0h",
                   reg_idx, stored, readback);
            fail_count++;
        end
    endtask

    task automatic configure(input logic [7:0] label, input logic [9:0] length);
        wait_drain();
        write_reg(REG_LABEL, {24'd0, label});
        write_reg(REG_LENGTH, {22'd0, length});
    endtask

    // one packet attempt, mostly well formed, sometimes broken or noise
    task automatic send_frame();
        int unsigned pick;
        int unsigned total;
        int unsigned cut;
        int unsigned n;
        logic [7:0]  start_b;
        logic [7:0]  label_b;
        logic [7:0]  end_b;
        logic [7:0]  b;
        logic [15:0] len_w;
        pick    = $urandom_range(99, 0);
        // every beat is refused as too long, so keep those frames short
        total   = (cfg_length > MAX_PAYLOAD) ? 5 : 5 + cfg_length;
        cut     = total;
        start_b = START_CODE;
        label_b = cfg_label;
        end_b   = END_CODE;
        len_w   = {6'd0, cfg_length};
        if (pick < 8)
            start_b = 8'($urandom_range(255, 0));
        else if (pick < 16)
            label_b = 8'($urandom_range(255, 0));
        else if (pick < 24)
            len_w = 16'($urandom_range(65535, 0));
        else if (pick < 32)
            end_b = 8'($urandom_range(255, 0));
        else if (pick < 40)
            cut = $urandom_range(total - 1, 0);
        if (pick >= 40 && pick < 46) begin
            n = $urandom_range(6, 1);
            repeat (n)
                send_beat(($urandom_range(3, 0) == 0) ? KIND_TIMEOUT : KIND_BYTE,
                          8'($urandom_range(255, 0)));
        end else begin
            for (int unsigned i = 0; i < total; i++) begin
                case (i)
                    0:       b = start_b;
                    1:       b = label_b;
                    2:       b = len_w[7:0];
                    3:       b = len_w[15:8];
                    default: b = (i == total - 1) ? end_b : 8'($urandom_range(255, 0));
                endcase
                if (i == cut)
                    send_beat(KIND_TIMEOUT, 8'($urandom_range(255, 0)));
                else
                    send_beat(KIND_BYTE, b);
            end
        end
        // resync the line after a fault
        if (rx_phase != PH_WAIT)
            send_beat(KIND_TIMEOUT, 8'($urandom_range(255, 0)));
    endtask

    task automatic run_setting(input logic [7:0] label, input logic [9:0] length,
                               input int unsigned budget);
        int unsigned first;
        configure(label, length);
        first = beats_sent;
        while (beats_sent - first < budget)
            send_frame();
    endtask

    task automatic test_directed_frames();
        t_byte_q seq;
        configure(8'h5A, 10'd1);
        seq = '{START_CODE, 8'h5A, 8'h01, 8'h00, 8'hFF, END_CODE};
        send_bytes(seq);
        seq = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h55};
        send_bytes(seq);
        send_beat(KIND_TIMEOUT, 8'hFF);
        seq = '{START_CODE, 8'hA5, 8'h01, 8'h00};
        send_bytes(seq);
        send_beat(KIND_TIMEOUT, 8'h00);
        seq = '{START_CODE, 8'h5A, 8'h01, 8'h80};
        send_bytes(seq);
        send_beat(KIND_TIMEOUT, 8'h00);
        seq = '{START_CODE, 8'h5A, 8'h01, 8'h00, 8'h00, START_CODE};
        send_bytes(seq);
        send_beat(KIND_TIMEOUT, 8'h00);
        send_beat(KIND_TIMEOUT, 8'h00);
        seq = '{START_CODE, 8'h5A};
        send_bytes(seq);
        send_beat(KIND_TIMEOUT, 8'hFF);
    endtask

    task automatic test_too_long();
        configure(8'hFF, 10'd1023);
        send_beat(KIND_TIMEOUT, 8'h00);
        send_beat(KIND_BYTE, START_CODE);
        send_beat(KIND_BYTE, 8'hFF);
    endtask

    task automatic test_random_settings();
        run_setting(8'h00, 10'd0, 50);
        run_setting(8'hFF, 10'd1, 50);
        run_setting(8'h5A, 10'd5, 60);
        run_setting(8'hA5, 10'd17, 60);
        run_setting(8'h81, 10'd601, 15);
        run_setting(8'h3C, 10'd2, 40);
    endtask

    task automatic test_backpressure();
        int unsigned first;
        configure(8'hC3, 10'd9);
        hold_left = 300;
        first     = beats_sent;
        while (beats_sent - first < 60)
            send_frame();
        // pause the sender until everything has drained
        wait_drain();
        first = beats_sent;
        while (beats_sent - first < 40)
            send_frame();
    endtask

    task automatic test_no_idle();
        idle_en = 1'b0;
        configure(8'h96, 10'd600);
        send_frame();
        run_setting(8'h69, 10'd3, 40);
        idle_en = 1'b1;
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_frames();
        test_too_long();
        test_random_settings();
        test_backpressure();
        test_no_idle();
        wait_drain();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
